>>> design/sdsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsp_pkg: shared types and constants for the shadow depth store
// Map geometry, fixed-point widths, command and register codes, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sdsp_pkg;

    // map geometry
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int X_W         = $clog2(MAX_WIDTH);
    localparam int Y_W         = $clog2(MAX_HEIGHT);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // field widths
    localparam int CMD_W      = 2;
    localparam int COORD_W    = 16;
    localparam int EXT_W      = COORD_W + 1;
    localparam int DEPTH_W    = 16;
    localparam int BIAS_W     = 14;
    localparam int CFG_DIM_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int LIT_W      = 4;

    // constants
    localparam logic signed [DEPTH_W-1:0] DEPTH_ONE = 16'sd16384;
    localparam logic [LIT_W-1:0]          LIT_ALL   = 4'd9;
    localparam logic [CFG_DIM_W-1:0]      MAP_WIDTH_RST  = 9'd256;
    localparam logic [CFG_DIM_W-1:0]      MAP_HEIGHT_RST = 9'd256;
    localparam logic [BIAS_W-1:0]         DEPTH_BIAS_RST = 14'd82;
    localparam logic signed [EXT_W-1:0]   EXT_ZERO  = '0;
    localparam logic signed [EXT_W-1:0]   EXT_ONE   = EXT_W'(1);
    localparam logic signed [EXT_W-1:0]   MAX_W_EXT = EXT_W'(MAX_WIDTH);
    localparam logic signed [EXT_W-1:0]   MAX_H_EXT = EXT_W'(MAX_HEIGHT);
    localparam logic [X_W-1:0]            X_LAST    = X_W'(MAX_WIDTH - 1);
    localparam logic [Y_W-1:0]            Y_LAST    = Y_W'(MAX_HEIGHT - 1);

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_SAMPLE = 2'd2
    } sdsp_cmd_code_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_HEIGHT = 2'd1,
        REG_DEPTH_BIAS = 2'd2
    } sdsp_reg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // latch transaction payload and walk bounds
        logic load_sweep;  // load bounds for a whole-store sweep
        logic step;        // advance the walk position
        logic mem_rd;      // read store at walk position
        logic mem_wr;      // write store at walk position
        logic wr_one;      // write 1.0 instead of the fill minimum
        logic count;       // read data feeds the lit counter next cycle
        logic emit;        // load the result register
    } sdsp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;   // walk position is the last of its area
        logic fill_empty;  // clamped fill rectangle covers nothing
        logic samp_edge;   // sample window reaches past the map edge
    } sdsp_status_t;

endpackage
`default_nettype wire

>>> design/sdsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsp_if: valid/ready channels of the shadow depth store
// Command channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface sdsp_req_if;
    import sdsp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic signed [COORD_W-1:0]  x_low;
    logic signed [COORD_W-1:0]  x_high;
    logic signed [COORD_W-1:0]  y_low;
    logic signed [COORD_W-1:0]  y_high;
    logic signed [DEPTH_W-1:0]  depth;

    modport source (
        output valid, command, x_low, x_high, y_low, y_high, depth,
        input  ready
    );
    modport sink (
        input  valid, command, x_low, x_high, y_low, y_high, depth,
        output ready
    );
endinterface

interface sdsp_rsp_if;
    import sdsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [LIT_W-1:0]  lit_count;
    logic              inside_map;

    modport source (
        output valid, lit_count, inside_map,
        input  ready
    );
    modport sink (
        input  valid, lit_count, inside_map,
        output ready
    );
endinterface
`default_nettype wire

>>> design/shadow_depth_store_pcf_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shadow_depth_store_pcf_unit: shadow depth map with 3x3 percentage-closer
// filtering
// Holds a 256x256 Q2.14 depth map; clears it, lowers a clamped rectangle
// to an occluder depth, or counts lit texels of a 3x3 window.
//
//   channel   dir   handshake          contents
//   req       in    req.valid/ready    command, x_low, x_high, y_low,
//                                      y_high, depth
//   rsp       out   rsp.valid/ready    lit_count, inside_map
//   cfg       in    cfg_we             cfg_index, cfg_data
//
// One transaction at a time; all store traffic goes through one
// single-port RAM. Sample: nine reads. Edge samples, empty fills and
// unknown commands go straight to the result. Fill: a read, then a
// write, per covered entry. Clear: 65536 writes. After reset a sweep
// writes 1.0 to every entry with req.ready low. A waiting result does
// not block the next transaction.
// ----------------------------------------------------------------------------
module shadow_depth_store_pcf_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    sdsp_req_if.sink                                  req,
    sdsp_rsp_if.source                                rsp,
    input  wire logic                                 cfg_we,
    input  wire logic [sdsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sdsp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import sdsp_pkg::*;

    sdsp_cmd_t    cmd;
    sdsp_status_t status;
    logic         in_ready;
    logic         out_valid;
    logic [LIT_W-1:0] lit_count;
    logic         inside_map;

    // sequencer
    sdsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .command   (req.command),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath and depth store
    sdsp_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .command    (req.command),
        .x_low      (req.x_low),
        .x_high     (req.x_high),
        .y_low      (req.y_low),
        .y_high     (req.y_high),
        .depth      (req.depth),
        .cmd        (cmd),
        .status     (status),
        .lit_count  (lit_count),
        .inside_map (inside_map)
    );

    // channel outputs
    assign req.ready      = in_ready;
    assign rsp.valid      = out_valid;
    assign rsp.lit_count  = lit_count;
    assign rsp.inside_map = inside_map;

endmodule
`default_nettype wire

>>> design/sdsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsp_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module sdsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // storage array and read register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> design/sdsp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsp_ctrl: command sequencer of the shadow depth store
// Runs the reset sweep, then one transaction at a time: clear sweep, fill
// read-modify-write walk, nine-read sample walk or none, then the result.
// ----------------------------------------------------------------------------
module sdsp_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [sdsp_pkg::CMD_W-1:0] command,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    input  wire sdsp_pkg::sdsp_status_t  status,
    output sdsp_pkg::sdsp_cmd_t          cmd
);
    import sdsp_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT_LOAD,
        ST_INIT_SWEEP,
        ST_IDLE,
        ST_CLEAR,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_SAMP_RD,
        ST_SAMP_TAIL,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT_LOAD:
            begin
                cmd.load_sweep = 1'b1;
                state_next     = ST_INIT_SWEEP;
            end
            ST_INIT_SWEEP:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wr_one = 1'b1;
                cmd.step   = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (command)
                        CMD_CLEAR:  state_next = ST_CLEAR;
                        CMD_FILL:   state_next = status.fill_empty ? ST_RESULT : ST_FILL_RD;
                        CMD_SAMPLE: state_next = status.samp_edge ? ST_RESULT : ST_SAMP_RD;
                        default:    state_next = ST_RESULT;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wr_one = 1'b1;
                cmd.step   = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_FILL_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.step   = 1'b1;
                state_next = status.walk_done ? ST_RESULT : ST_FILL_RD;
            end
            ST_SAMP_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.count  = 1'b1;
                cmd.step   = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_SAMP_TAIL;
                end
            end
            ST_SAMP_TAIL:
            begin
                // last neighbour is counted in this cycle
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT_LOAD;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> design/sdsp_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsp_dpath: datapath of the shadow depth store
// Configuration registers, rectangle clamp and edge test, area walker,
// depth store, fill minimum, sample compare and lit counter, result register.
// ----------------------------------------------------------------------------
module sdsp_dpath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [sdsp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [sdsp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic [sdsp_pkg::CMD_W-1:0]            command,
    input  wire logic signed [sdsp_pkg::COORD_W-1:0]   x_low,
    input  wire logic signed [sdsp_pkg::COORD_W-1:0]   x_high,
    input  wire logic signed [sdsp_pkg::COORD_W-1:0]   y_low,
    input  wire logic signed [sdsp_pkg::COORD_W-1:0]   y_high,
    input  wire logic signed [sdsp_pkg::DEPTH_W-1:0]   depth,
    input  wire sdsp_pkg::sdsp_cmd_t                   cmd,
    output sdsp_pkg::sdsp_status_t                     status,
    output logic [sdsp_pkg::LIT_W-1:0]                 lit_count,
    output logic                                       inside_map
);
    import sdsp_pkg::*;

    logic [CFG_DIM_W-1:0]       map_width_reg;
    logic [CFG_DIM_W-1:0]       map_height_reg;
    logic [BIAS_W-1:0]          depth_bias_reg;

    logic signed [EXT_W-1:0]    w_eff;
    logic signed [EXT_W-1:0]    h_eff;
    logic signed [EXT_W-1:0]    w_m1;
    logic signed [EXT_W-1:0]    h_m1;
    logic signed [EXT_W-1:0]    xl_ext;
    logic signed [EXT_W-1:0]    xh_ext;
    logic signed [EXT_W-1:0]    yl_ext;
    logic signed [EXT_W-1:0]    yh_ext;
    logic signed [EXT_W-1:0]    fxl;
    logic signed [EXT_W-1:0]    fxh;
    logic signed [EXT_W-1:0]    fyl;
    logic signed [EXT_W-1:0]    fyh;
    logic signed [EXT_W-1:0]    sxm1;
    logic signed [EXT_W-1:0]    sxp1;
    logic signed [EXT_W-1:0]    sym1;
    logic signed [EXT_W-1:0]    syp1;
    logic                       fill_empty;
    logic                       samp_edge;
    logic                       is_sample;

    logic [X_W-1:0]             ld_x_start;
    logic [X_W-1:0]             ld_x_end;
    logic [Y_W-1:0]             ld_y_start;
    logic [Y_W-1:0]             ld_y_end;

    logic [X_W-1:0]             x_reg;
    logic [X_W-1:0]             x_start_reg;
    logic [X_W-1:0]             x_end_reg;
    logic [Y_W-1:0]             y_reg;
    logic [Y_W-1:0]             y_end_reg;
    logic                       walk_done;

    logic signed [DEPTH_W-1:0]  depth_reg;
    logic signed [EXT_W-1:0]    recv_reg;
    logic [LIT_W-1:0]           lit_reg;
    logic                       inside_reg;
    logic                       count_pending_reg;
    logic [LIT_W-1:0]           lit_out_reg;
    logic                       inside_out_reg;

    logic [ADDR_W-1:0]          mem_addr;
    logic [DEPTH_W-1:0]         mem_wdata;
    logic [DEPTH_W-1:0]         ram_rdata;
    logic signed [DEPTH_W-1:0]  stored;
    logic signed [EXT_W-1:0]    stored_ext;
    logic signed [DEPTH_W-1:0]  fill_min;
    logic                       lit_hit;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= MAP_WIDTH_RST;
            map_height_reg <= MAP_HEIGHT_RST;
            depth_bias_reg <= DEPTH_BIAS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data[CFG_DIM_W-1:0];
                REG_MAP_HEIGHT: map_height_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_DEPTH_BIAS: depth_bias_reg <= cfg_data[BIAS_W-1:0];
                default:        ;
            endcase
        end
    end

    // effective map size: zero acts as one, capped at the store size
    always_comb
    begin
        if (map_width_reg == '0)
        begin
            w_eff = EXT_ONE;
        end
        else if (EXT_W'(map_width_reg) > MAX_W_EXT)
        begin
            w_eff = MAX_W_EXT;
        end
        else
        begin
            w_eff = EXT_W'(map_width_reg);
        end

        if (map_height_reg == '0)
        begin
            h_eff = EXT_ONE;
        end
        else if (EXT_W'(map_height_reg) > MAX_H_EXT)
        begin
            h_eff = MAX_H_EXT;
        end
        else
        begin
            h_eff = EXT_W'(map_height_reg);
        end
    end

    assign w_m1 = w_eff - EXT_ONE;
    assign h_m1 = h_eff - EXT_ONE;

    // sign-extended coordinates
    assign xl_ext = {x_low[COORD_W-1], x_low};
    assign xh_ext = {x_high[COORD_W-1], x_high};
    assign yl_ext = {y_low[COORD_W-1], y_low};
    assign yh_ext = {y_high[COORD_W-1], y_high};

    // fill rectangle clamp
    assign fxl = (xl_ext < EXT_ZERO) ? EXT_ZERO : xl_ext;
    assign fxh = (xh_ext > w_m1) ? w_m1 : xh_ext;
    assign fyl = (yl_ext < EXT_ZERO) ? EXT_ZERO : yl_ext;
    assign fyh = (yh_ext > h_m1) ? h_m1 : yh_ext;
    assign fill_empty = (fxl > fxh) || (fyl > fyh);

    // sample window edge test and bounds
    assign samp_edge = (xl_ext < EXT_ONE) || (xl_ext >= w_m1)
                    || (yl_ext < EXT_ONE) || (yl_ext >= h_m1);
    assign sxm1 = xl_ext - EXT_ONE;
    assign sxp1 = xl_ext + EXT_ONE;
    assign sym1 = yl_ext - EXT_ONE;
    assign syp1 = yl_ext + EXT_ONE;
    assign is_sample = (command == CMD_SAMPLE);

    // walk bounds for the incoming transaction
    always_comb
    begin
        ld_x_start = '0;
        ld_x_end   = X_LAST;
        ld_y_start = '0;
        ld_y_end   = Y_LAST;
        if (!cmd.load_sweep)
        begin
            case (command)
                CMD_FILL:
                begin
                    ld_x_start = fxl[X_W-1:0];
                    ld_x_end   = fxh[X_W-1:0];
                    ld_y_start = fyl[Y_W-1:0];
                    ld_y_end   = fyh[Y_W-1:0];
                end
                CMD_SAMPLE:
                begin
                    ld_x_start = sxm1[X_W-1:0];
                    ld_x_end   = sxp1[X_W-1:0];
                    ld_y_start = sym1[Y_W-1:0];
                    ld_y_end   = syp1[Y_W-1:0];
                end
                default:
                begin
                    ld_x_start = '0;
                    ld_x_end   = X_LAST;
                    ld_y_start = '0;
                    ld_y_end   = Y_LAST;
                end
            endcase
        end
    end

    // area walker, row by row
    always_ff @(posedge clk)
    begin
        if (cmd.load || cmd.load_sweep)
        begin
            x_reg       <= ld_x_start;
            x_start_reg <= ld_x_start;
            x_end_reg   <= ld_x_end;
            y_reg       <= ld_y_start;
            y_end_reg   <= ld_y_end;
        end
        else if (cmd.step)
        begin
            if (x_reg == x_end_reg)
            begin
                x_reg <= x_start_reg;
                y_reg <= y_reg + 1'b1;
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
            end
        end
    end

    assign walk_done = (x_reg == x_end_reg) && (y_reg == y_end_reg);

    // depth store access
    assign mem_addr = ADDR_W'(ADDR_W'(y_reg) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(x_reg);
    assign stored     = ram_rdata;
    assign stored_ext = {stored[DEPTH_W-1], stored};
    assign fill_min   = (depth_reg < stored) ? depth_reg : stored;
    assign mem_wdata  = cmd.wr_one ? DEPTH_ONE : fill_min;

    sdsp_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.mem_wr),
        .re    (cmd.mem_rd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (ram_rdata)
    );

    // transaction payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            depth_reg <= depth;
            recv_reg  <= EXT_W'(depth) - EXT_W'(depth_bias_reg);
        end
    end

    // read data of a sample read arrives in the following cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_pending_reg <= 1'b0;
        end
        else
        begin
            count_pending_reg <= cmd.count;
        end
    end

    assign lit_hit = (recv_reg <= stored_ext);

    // lit counter
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lit_reg    <= (is_sample && samp_edge) ? LIT_ALL : '0;
            inside_reg <= is_sample && !samp_edge;
        end
        else if (count_pending_reg && lit_hit)
        begin
            lit_reg <= lit_reg + 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            lit_out_reg    <= lit_reg;
            inside_out_reg <= inside_reg;
        end
    end

    assign status.walk_done  = walk_done;
    assign status.fill_empty = fill_empty;
    assign status.samp_edge  = samp_edge;
    assign lit_count         = lit_out_reg;
    assign inside_map        = inside_out_reg;

endmodule
`default_nettype wire

>>> design/sdsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsp_checker: port-level checks of the shadow depth store
// Result hold under stall, result value ranges, busy after a transaction.
// ----------------------------------------------------------------------------
module sdsp_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic                          req_ready,
    input  wire logic                          rsp_valid,
    input  wire logic                          rsp_ready,
    input  wire logic [sdsp_pkg::LIT_W-1:0]    lit_count,
    input  wire logic                          inside_map
);
    import sdsp_pkg::*;

    // stalled result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(lit_count) && $stable(inside_map))
        else $error("result changed while stalled");

    // at most nine neighbours
    a_lit_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> lit_count <= LIT_ALL)
        else $error("lit count above nine");

    // results without a full window are all lit or none
    a_outside_vals: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !inside_map |-> lit_count == '0 || lit_count == LIT_ALL)
        else $error("partial count outside the map");

    // ready drops after every accepted transaction
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready held after a transaction");

endmodule

bind shadow_depth_store_pcf_unit sdsp_checker u_sdsp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .lit_count  (rsp.lit_count),
    .inside_map (rsp.inside_map)
);
`default_nettype wire
